FILE: hw/rtl/thermistor_average_to_temperature_defines.svh
// Assertion helpers for the file that checks its own logic.
`ifndef THERMISTOR_AVERAGE_TO_TEMPERATURE_DEFINES_SVH
`define THERMISTOR_AVERAGE_TO_TEMPERATURE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define THAV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define THAV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/thav_pkg.sv
package thav_pkg;

  localparam int ADC_BITS_DEF    = 10;
  localparam int MAX_SAMPLES_DEF = 255;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int TEMP_W     = 19;
  localparam int STATUS_W   = 2;
  localparam int SUM_OUT_W  = 18;
  localparam int TICK_W     = 17;
  localparam int FRAC_W     = 32;
  localparam int KQ_W       = 42;
  localparam int TQ_W       = 50;
  localparam int DIV_W      = 65;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL = 3'd0,
    CFG_COUNT    = 3'd1,
    CFG_RES      = 3'd2,
    CFG_COEF_A   = 3'd3,
    CFG_COEF_B   = 3'd4,
    CFG_COEF_C   = 3'd5,
    CFG_UNIT     = 3'd6
  } cfg_idx_t;

  localparam logic [1:0] UNIT_KELVIN  = 2'd0;
  localparam logic [1:0] UNIT_CELSIUS = 2'd1;
  localparam logic [1:0] UNIT_FAHR    = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

  localparam logic [63:0] LN2_Q63     = 64'h58B90BFBE8E7BCD6;
  localparam logic [63:0] RECIP5_Q63  = 64'h199999999999999A;
  localparam logic [63:0] RECIP25_Q63 = 64'h051EB851EB851EB9;
  localparam logic [63:0] K_CLAMP     = 64'd1 << 40;
  localparam logic [63:0] RECIP_LIMIT = 64'd1 << 24;
  localparam int          KELVIN_OFS  = 349632;
  localparam int          FAHR_OFS    = 8192;
  localparam int          TEMP_MAX    = 262143;
  localparam int          TEMP_MIN    = -262144;

  localparam logic [15:0] RST_INTERVAL = 16'd1000;
  localparam logic [7:0]  RST_COUNT    = 8'd10;
  localparam logic [23:0] RST_RES      = 24'd10000;
  localparam logic [1:0]  RST_UNIT     = UNIT_CELSIUS;

  typedef struct packed {
    logic start;
    logic sh63;
  } thav_mul_req_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? (64'd0 - $unsigned(a)) : $unsigned(a);
  endfunction

endpackage

FILE: hw/rtl/thav_if.sv
interface thav_in_if import thav_pkg::*; #(parameter int ADC_BITS = ADC_BITS_DEF);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_reading;

  modport source (output valid, output adc_reading, input ready);
  modport sink (input valid, input adc_reading, output ready);
endinterface

interface thav_out_if import thav_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [TEMP_W-1:0]   temperature;
  logic [STATUS_W-1:0]        status;
  logic [SUM_OUT_W-1:0]       sample_sum;

  modport source (output valid, output temperature, output status, output sample_sum,
                  input ready);
  modport sink (input valid, input temperature, input status, input sample_sum,
                output ready);
endinterface

FILE: hw/rtl/thav_mul.sv
module thav_mul import thav_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  thav_mul_req_t       req,
  input  logic signed [63:0]  a,
  input  logic signed [63:0]  b,
  output logic                done,
  output logic signed [63:0]  res
);

  logic [63:0]        ua_r, ub_r;
  logic               neg_r, sh63_r, busy_r, done_r;
  logic [2:0]         step_r;
  logic [127:0]       acc_r;
  logic signed [63:0] res_r;

  logic [31:0]        half_a, half_b;
  logic [63:0]        prod;
  logic [127:0]       pp, shifted;
  logic signed [63:0] sat;

  always_comb begin
    half_a  = step_r[1] ? ua_r[63:32] : ua_r[31:0];
    half_b  = step_r[0] ? ub_r[63:32] : ub_r[31:0];
    prod    = half_a * half_b;
    case (step_r[1:0])
      2'd0:    pp = {64'd0, prod};
      2'd3:    pp = {prod, 64'd0};
      default: pp = {32'd0, prod, 32'd0};
    endcase
    shifted = sh63_r ? (acc_r >> 63) : (acc_r >> 32);
    if (neg_r) begin
      if (shifted[127:64] != '0 || shifted[63]) begin
        sat = 64'sh8000000000000000;
      end else begin
        sat = $signed(64'd0 - shifted[63:0]);
      end
    end else begin
      if (shifted[127:63] != '0) begin
        sat = 64'sh7FFFFFFFFFFFFFFF;
      end else begin
        sat = $signed(shifted[63:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        ua_r   <= mag64(a);
        ub_r   <= mag64(b);
        neg_r  <= a[63] ^ b[63];
        sh63_r <= req.sh63;
        acc_r  <= '0;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (step_r != 3'd4) begin
          acc_r  <= acc_r + pp;
          step_r <= step_r + 3'd1;
        end else begin
          res_r  <= sat;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: hw/rtl/thav_log.sv
module thav_log import thav_pkg::*; #(
  parameter int V_W = 42
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [V_W-1:0]                    v,
  output logic                              done,
  output logic [$clog2(V_W)+FRAC_W-1:0]     log2_out
);

  localparam int KW = $clog2(V_W);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_SQR  = 3'b100
  } lstate_t;

  lstate_t           state_r;
  logic [V_W-1:0]    v_r;
  logic [KW-1:0]     k_r;
  logic [31:0]       m_r, frac_r;
  logic [4:0]        it_r;
  logic              done_r;
  logic [63:0]       sq;
  logic [32:0]       s33;

  always_comb begin
    sq  = m_r * m_r;
    s33 = sq[63:31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        L_IDLE: begin
          if (start) begin
            v_r     <= v;
            k_r     <= KW'(V_W - 1);
            state_r <= L_NORM;
          end
        end
        L_NORM: begin
          if (v_r[V_W-1]) begin
            m_r     <= v_r[V_W-1 -: 32];
            frac_r  <= '0;
            it_r    <= '0;
            state_r <= L_SQR;
          end else begin
            v_r <= v_r << 1;
            k_r <= k_r - 1'b1;
          end
        end
        L_SQR: begin
          m_r    <= s33[32] ? s33[32:1] : s33[31:0];
          frac_r <= {frac_r[30:0], s33[32]};
          if (it_r == 5'd31) begin
            done_r  <= 1'b1;
            state_r <= L_IDLE;
          end else begin
            it_r <= it_r + 5'd1;
          end
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign log2_out = {k_r, frac_r};

endmodule

FILE: hw/rtl/thav_div.sv
module thav_div import thav_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [63:0]      divisor,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  localparam int CW = $clog2(DIV_W);

  logic [63:0]      rem_r, d_r;
  logic [DIV_W-1:0] dvd_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [64:0]      r2, diff;
  logic             ge;

  always_comb begin
    r2   = {rem_r, dvd_r[DIV_W-1]};
    diff = r2 - {1'b0, d_r};
    ge   = r2 >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        d_r    <= divisor;
        dvd_r  <= dividend;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[63:0] : r2[63:0];
        dvd_r <= {dvd_r[DIV_W-2:0], ge};
        if (cnt_r == CW'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = dvd_r;

endmodule

FILE: hw/rtl/thermistor_average_to_temperature.sv
// Takes one tick item per cycle while idle; a tick that does not close a set of samples
// leaves the block idle. A tick that closes a set starts a conversion during which the input
// is not ready. Each of the two logarithms takes one normalize step per leading zero of
// its 24+ADC_BITS+ceil(log2(MAX_SAMPLES+1)) bit operand before its squaring steps; the products
// (seven, or six for Kelvin output) use the shared 32x32 partial-product multiplier, and
// the reciprocal pass uses the restoring divider.
// A conversion may wait for the output register. Kelvin output skips the final product,
// a clamped reciprocal skips the divider, and a zero sum, resistance or denominator goes
// from the prepare step straight to the output step.
// A finished result waits in the output register while new ticks are taken.
`include "thermistor_average_to_temperature_defines.svh"

module thermistor_average_to_temperature import thav_pkg::*; #(
  parameter int ADC_BITS    = ADC_BITS_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  thav_in_if.sink               in_ch,
  thav_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NW    = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = ADC_BITS + NW;
  localparam int NUM_W = 24 + SUM_W;
  localparam int LOG_W = $clog2(NUM_W) + FRAC_W;
  localparam int CMP_W = (NW > 8) ? NW : 8;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_PREP  = 14'b00000000000010,
    S_LOGN  = 14'b00000000000100,
    S_LNN   = 14'b00000000001000,
    S_LOGD  = 14'b00000000010000,
    S_LND   = 14'b00000000100000,
    S_POLY  = 14'b00000001000000,
    S_RECIP = 14'b00000010000000,
    S_DIVK  = 14'b00000100000000,
    S_CONV  = 14'b00001000000000,
    S_CONV2 = 14'b00010000000000,
    S_DIVT  = 14'b00100000000000,
    S_SAT   = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  logic [15:0]               interval_r;
  logic [7:0]                count_r;
  logic [23:0]               res_r;
  logic signed [47:0]        coef_a_r, coef_b_r, coef_c_r;
  logic [1:0]                unit_r;

  state_t                    state_r;
  logic [TICK_W-1:0]         tick_r;
  logic [NW-1:0]             cnt_r, n_r;
  logic [SUM_W-1:0]          sum_r, s_r, den_r;
  logic [NUM_W-1:0]          num_r;
  logic signed [63:0]        lnn_r, l_r, p_r, y_r;
  logic [1:0]                op_r;
  logic signed [KQ_W-1:0]    k_r;
  logic signed [TQ_W-1:0]    x_r, t_r;
  logic [DIV_W-1:0]          div_n_r;
  logic [63:0]               div_d_r;
  logic                      log_go_r, mul_go_r, div_go_r;
  logic signed [TEMP_W-1:0]  tfin_r, out_temp_r;
  logic [STATUS_W-1:0]       stat_r, out_stat_r;
  logic [SUM_OUT_W-1:0]      out_sum_r;
  logic                      out_valid_r;

  logic [TICK_W-1:0]         t_inc;
  logic [NW-1:0]             n_eff, new_cnt;
  logic [SUM_W-1:0]          new_sum, den_c;
  logic [CMP_W-1:0]          sc_ext;
  logic [NUM_W-1:0]          log_v;
  logic                      log_done, mul_done, div_done;
  logic [LOG_W-1:0]          log_out;
  logic signed [63:0]        mul_a, mul_b, mul_res;
  thav_mul_req_t             mul_req;
  logic [DIV_W-1:0]          div_quot;
  logic [63:0]               y_mag;
  logic signed [TQ_W-1:0]    kx, w;
  logic                      fahr;
  logic [SUM_OUT_W+SUM_W-1:0] sum_pad;

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF;
    end
    return s[63:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= RST_INTERVAL;
      count_r    <= RST_COUNT;
      res_r      <= RST_RES;
      coef_a_r   <= '0;
      coef_b_r   <= '0;
      coef_c_r   <= '0;
      unit_r     <= RST_UNIT;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INTERVAL: interval_r <= cfg_data[15:0];
        CFG_COUNT:    count_r    <= cfg_data[7:0];
        CFG_RES:      res_r      <= cfg_data[23:0];
        CFG_COEF_A:   coef_a_r   <= $signed(cfg_data);
        CFG_COEF_B:   coef_b_r   <= $signed(cfg_data);
        CFG_COEF_C:   coef_c_r   <= $signed(cfg_data);
        CFG_UNIT:     unit_r     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    t_inc   = (tick_r == '1) ? tick_r : tick_r + 1'b1;
    sc_ext  = CMP_W'(count_r);
    if (count_r == 8'd0) begin
      n_eff = NW'(1);
    end else if (sc_ext > CMP_W'(MAX_SAMPLES)) begin
      n_eff = NW'(MAX_SAMPLES);
    end else begin
      n_eff = sc_ext[NW-1:0];
    end
    new_cnt = cnt_r + 1'b1;
    new_sum = sum_r + SUM_W'(in_ch.adc_reading);
    den_c   = {n_r, {ADC_BITS{1'b0}}} - s_r;
    log_v   = (state_r == S_LOGD) ? NUM_W'(den_r) : num_r;
    fahr    = (unit_r == UNIT_FAHR);
    y_mag   = mag64(y_r);
    kx      = TQ_W'(k_r);
    w       = fahr ? ((x_r <<< 3) + x_r) : x_r;
    sum_pad = {{SUM_OUT_W{1'b0}}, s_r};

    mul_a = l_r;
    mul_b = l_r;
    if (state_r == S_LNN || state_r == S_LND) begin
      mul_a = $signed({{(64-LOG_W){1'b0}}, log_out});
      mul_b = $signed(LN2_Q63);
    end else if (state_r == S_DIVT) begin
      mul_a = 64'(w);
      mul_b = fahr ? $signed(RECIP25_Q63) : $signed(RECIP5_Q63);
    end else begin
      case (op_r)
        2'd0:    mul_a = l_r;
        2'd1:    mul_a = p_r;
        2'd2:    mul_a = 64'(coef_b_r);
        default: mul_a = 64'(coef_c_r);
      endcase
      mul_b = (op_r == 2'd3) ? p_r : l_r;
    end
    mul_req.start = mul_go_r;
    mul_req.sh63  = (state_r == S_LNN || state_r == S_LND || state_r == S_DIVT);
  end

  thav_log #(.V_W(NUM_W)) u_log (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (log_go_r),
    .v        (log_v),
    .done     (log_done),
    .log2_out (log_out)
  );

  thav_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  thav_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (div_n_r),
    .divisor  (div_d_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      log_go_r    <= 1'b0;
      mul_go_r    <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= '0;
    end else begin
      log_go_r <= 1'b0;
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            if (t_inc <= {1'b0, interval_r}) begin
              tick_r <= t_inc;
            end else begin
              tick_r <= '0;
              if (new_cnt >= n_eff) begin
                s_r     <= new_sum;
                n_r     <= new_cnt;
                sum_r   <= '0;
                cnt_r   <= '0;
                state_r <= S_PREP;
              end else begin
                sum_r <= new_sum;
                cnt_r <= new_cnt;
              end
            end
          end
        end
        S_PREP: begin
          num_r <= res_r * s_r;
          den_r <= den_c;
          if (s_r == '0 || res_r == '0 || den_c == '0) begin
            tfin_r  <= '0;
            stat_r  <= STATUS_ZERO;
            state_r <= S_FIN;
          end else begin
            log_go_r <= 1'b1;
            state_r  <= S_LOGN;
          end
        end
        S_LOGN: begin
          if (log_done) begin
            mul_go_r <= 1'b1;
            state_r  <= S_LNN;
          end
        end
        S_LNN: begin
          if (mul_done) begin
            lnn_r    <= mul_res;
            log_go_r <= 1'b1;
            state_r  <= S_LOGD;
          end
        end
        S_LOGD: begin
          if (log_done) begin
            mul_go_r <= 1'b1;
            state_r  <= S_LND;
          end
        end
        S_LND: begin
          if (mul_done) begin
            l_r      <= lnn_r - mul_res;
            op_r     <= 2'd0;
            mul_go_r <= 1'b1;
            state_r  <= S_POLY;
          end
        end
        S_POLY: begin
          if (mul_done) begin
            case (op_r)
              2'd0:    p_r <= mul_res;
              2'd1:    p_r <= mul_res;
              2'd2:    y_r <= sadd64(64'(coef_a_r), mul_res);
              default: y_r <= sadd64(y_r, mul_res);
            endcase
            if (op_r == 2'd3) begin
              state_r <= S_RECIP;
            end else begin
              op_r     <= op_r + 2'd1;
              mul_go_r <= 1'b1;
            end
          end
        end
        S_RECIP: begin
          if (y_r == '0) begin
            tfin_r  <= '0;
            stat_r  <= STATUS_ZERO;
            state_r <= S_FIN;
          end else if (y_mag <= RECIP_LIMIT) begin
            k_r     <= y_r[63] ? -$signed(KQ_W'(K_CLAMP)) : $signed(KQ_W'(K_CLAMP));
            state_r <= S_CONV;
          end else begin
            div_n_r  <= DIV_W'(1) << 64;
            div_d_r  <= y_mag;
            div_go_r <= 1'b1;
            state_r  <= S_DIVK;
          end
        end
        S_DIVK: begin
          if (div_done) begin
            k_r <= y_r[63] ? -$signed({1'b0, div_quot[KQ_W-2:0]})
                           : $signed({1'b0, div_quot[KQ_W-2:0]});
            state_r <= S_CONV;
          end
        end
        S_CONV: begin
          if (unit_r == UNIT_KELVIN) begin
            t_r     <= kx;
            state_r <= S_SAT;
          end else begin
            x_r     <= (kx <<< 2) + kx - TQ_W'(KELVIN_OFS);
            state_r <= S_CONV2;
          end
        end
        S_CONV2: begin
          mul_go_r <= 1'b1;
          state_r  <= S_DIVT;
        end
        S_DIVT: begin
          if (mul_done) begin
            t_r <= TQ_W'(mul_res) + (fahr ? TQ_W'(FAHR_OFS) : TQ_W'(0));
            state_r <= S_SAT;
          end
        end
        S_SAT: begin
          if (t_r > TQ_W'(TEMP_MAX)) begin
            tfin_r <= TEMP_W'(TEMP_MAX);
            stat_r <= STATUS_SAT;
          end else if (t_r < TQ_W'(TEMP_MIN)) begin
            tfin_r <= TEMP_W'(TEMP_MIN);
            stat_r <= STATUS_SAT;
          end else begin
            tfin_r <= t_r[TEMP_W-1:0];
            stat_r <= STATUS_OK;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_temp_r  <= tfin_r;
            out_stat_r  <= stat_r;
            out_sum_r   <= sum_pad[SUM_OUT_W-1:0];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.temperature = out_temp_r;
  assign out_ch.status      = out_stat_r;
  assign out_ch.sample_sum  = out_sum_r;

  `THAV_ASSERT_NXT(a_fin_loads, state_r == S_FIN && !out_valid_r, out_valid_r, "result lost")
  `THAV_ASSERT_IMP(a_zero_temp, out_valid_r && out_stat_r == STATUS_ZERO, out_temp_r == '0, "zero status with nonzero temperature")
  `THAV_ASSERT_IMP(a_sat_rail, out_valid_r && out_stat_r == STATUS_SAT, out_temp_r == TEMP_W'(TEMP_MAX) || out_temp_r == TEMP_W'(TEMP_MIN), "saturated temperature off the rail")
  `THAV_ASSERT_IMP(a_mul_owner, mul_done, state_r == S_LNN || state_r == S_LND || state_r == S_POLY || state_r == S_DIVT, "product finished outside its step")

endmodule
